// ----- design/cemd_pkg.sv -----
// Package for the controller event message decoder.
// It holds the magic words, the event kind codes and the result packing widths.
// It depends on nothing else.
package cemd_pkg;

  localparam logic [31:0] MAGIC_BUTTON    = 32'h0373_4e00;
  localparam logic [31:0] MAGIC_KNOB      = 32'h0365_4e00;
  localparam logic [31:0] MAGIC_MAIN_KNOB = 32'h0377_4e00;
  localparam logic [31:0] MAGIC_PAD       = 32'h0350_4e00;

  // Minimum message lengths and length thresholds in bytes, and the byte count limit
  localparam logic [4:0] LEN_BUTTON    = 5'd21;
  localparam logic [4:0] LEN_KNOB      = 5'd24;
  localparam logic [4:0] LEN_MAIN_KNOB = 5'd20;
  localparam logic [4:0] LEN_MAIN_WIDE = 5'd24;
  localparam logic [4:0] LEN_PAD       = 5'd28;
  localparam logic [4:0] COUNT_MAX     = 5'd31;

  // Byte offsets of the captured words
  localparam logic [4:0] OFS_W12     = 5'd12;
  localparam logic [4:0] OFS_W16     = 5'd16;
  localparam logic [4:0] OFS_W20     = 5'd20;
  localparam logic [4:0] OFS_W24     = 5'd24;
  localparam logic [4:0] OFS_W24_END = 5'd27;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_BUTTON    = 3'd1,
    KIND_KNOB      = 3'd2,
    KIND_MAIN_KNOB = 3'd3,
    KIND_PAD       = 3'd4
  } event_kind_t;

  localparam int RESULT_BITS = 3 + 32 + 32 + 32 + 1;
  localparam int TDATA_OUT_W = ((RESULT_BITS + 7) / 8) * 8;

endpackage

// ----- design/controller_event_message_decoder.sv -----
// Controller event message decoder: byte stream in, one decoded event per message out.
// Depends on cemd_pkg (magic words, kind codes, widths).
//
// Usage: message bytes stream in one per transfer, with tlast on the final byte.
// The block takes one byte every cycle while the result side keeps up. Bytes
// only update a saturating count and the captured words at offsets 0, 12, 16,
// 20 and 24. On the last byte the captured words and the length are copied
// into a snapshot register and the working state clears, so the next message
// can start in the following cycle. The snapshot is decoded in one pass into
// the output register, which holds the result until m_axis_tready takes it.
// s_axis_tready drops only while both the snapshot and output registers
// are full and m_axis_tready is low.
module controller_event_message_decoder
  import cemd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
  input  logic                   s_axis_tlast,  // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] event_kind, [34:3] control_id, [66:35] rotation,
  // [98:67] pressure, [99] pressed, [103:100] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

  // working state
  logic [4:0]  byte_count;
  logic [31:0] magic_word, word_at_12, word_at_16, word_at_20, word_at_24;
  logic [4:0]  byte_count_next;
  logic [31:0] magic_next, w12_next, w16_next, w20_next, w24_next;

  // snapshot stage
  logic        snap_valid;
  logic [4:0]  snap_len;
  logic [31:0] snap_magic, snap_w12, snap_w16, snap_w20, snap_w24;

  // result stage
  logic        out_valid;
  event_kind_t out_kind;
  logic [31:0] out_id, out_rot, out_pres;
  logic        out_pressed;

  event_kind_t dec_kind;
  logic [31:0] dec_id, dec_rot, dec_pres;
  logic        dec_pressed;
  logic [31:0] main_rot;

  logic out_free, snap_free, in_xfer;

  assign out_free      = !out_valid || m_axis_tready;
  assign snap_free     = !snap_valid || out_free;
  assign s_axis_tready = snap_free;
  assign in_xfer       = s_axis_tvalid && snap_free;

  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                            input logic [7:0] b);
    logic [31:0] r;
    r = w;
    unique case (lane)
      2'd0: r[7:0]   = b;
      2'd1: r[15:8]  = b;
      2'd2: r[23:16] = b;
      2'd3: r[31:24] = b;
      default: r = w;
    endcase
    return r;
  endfunction

  // capture of the current byte
  always_comb begin
    magic_next = magic_word;
    w12_next   = word_at_12;
    w16_next   = word_at_16;
    w20_next   = word_at_20;
    w24_next   = word_at_24;
    priority if (byte_count < 5'd4) begin
      magic_next = put_byte(magic_word, byte_count[1:0], s_axis_tdata);
    end else if (byte_count >= OFS_W12 && byte_count < OFS_W16) begin
      w12_next = put_byte(word_at_12, byte_count[1:0], s_axis_tdata);
    end else if (byte_count >= OFS_W16 && byte_count < OFS_W20) begin
      w16_next = put_byte(word_at_16, byte_count[1:0], s_axis_tdata);
    end else if (byte_count >= OFS_W20 && byte_count < OFS_W24) begin
      w20_next = put_byte(word_at_20, byte_count[1:0], s_axis_tdata);
    end else if (byte_count >= OFS_W24 && byte_count <= OFS_W24_END) begin
      w24_next = put_byte(word_at_24, byte_count[1:0], s_axis_tdata);
    end else begin
      magic_next = magic_word;
    end
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 5'd1 : byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      magic_word <= '0;
      word_at_12 <= '0;
      word_at_16 <= '0;
      word_at_20 <= '0;
      word_at_24 <= '0;
    end else if (in_xfer) begin
      if (s_axis_tlast) begin
        byte_count <= '0;
        magic_word <= '0;
        word_at_12 <= '0;
        word_at_16 <= '0;
        word_at_20 <= '0;
        word_at_24 <= '0;
      end else begin
        byte_count <= byte_count_next;
        magic_word <= magic_next;
        word_at_12 <= w12_next;
        word_at_16 <= w16_next;
        word_at_20 <= w20_next;
        word_at_24 <= w24_next;
      end
    end
  end

  // snapshot register
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= in_xfer && s_axis_tlast;
    end
    if (in_xfer && s_axis_tlast) begin
      snap_len   <= byte_count_next;
      snap_magic <= magic_next;
      snap_w12   <= w12_next;
      snap_w16   <= w16_next;
      snap_w20   <= w20_next;
      snap_w24   <= w24_next;
    end
  end

  // decode
  assign main_rot = (snap_len >= LEN_MAIN_WIDE) ? snap_w20 : snap_w16;

  always_comb begin
    dec_kind    = KIND_NONE;
    dec_id      = '0;
    dec_rot     = '0;
    dec_pres    = '0;
    dec_pressed = 1'b0;
    unique case (snap_magic)
      MAGIC_BUTTON: begin
        if (snap_len >= LEN_BUTTON && snap_w12 == 32'd1) begin
          dec_kind    = KIND_BUTTON;
          dec_id      = snap_w16;
          dec_pressed = |snap_w20[7:0];
        end
      end
      MAGIC_KNOB: begin
        if (snap_len >= LEN_KNOB && snap_w16[31:3] == '0 && snap_w20 != '0) begin
          dec_kind = KIND_KNOB;
          dec_id   = snap_w16;
          dec_rot  = snap_w20;
        end
      end
      MAGIC_MAIN_KNOB: begin
        if (snap_len >= LEN_MAIN_KNOB && main_rot != '0) begin
          dec_kind = KIND_MAIN_KNOB;
          dec_rot  = main_rot;
        end
      end
      MAGIC_PAD: begin
        if (snap_len >= LEN_PAD && snap_w16[31:4] == '0) begin
          dec_kind    = KIND_PAD;
          // (3 - row) * 4 + column, row in bits 3:2
          dec_id      = {28'd0, ~snap_w16[3:2], snap_w16[1:0]};
          dec_pres    = snap_w24;
          dec_pressed = snap_w24 != '0;
        end
      end
      default: dec_kind = KIND_NONE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_valid;
    end
    if (out_free && snap_valid) begin
      out_kind    <= dec_kind;
      out_id      <= dec_id;
      out_rot     <= dec_rot;
      out_pres    <= dec_pres;
      out_pressed <= dec_pressed;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TDATA_OUT_W - RESULT_BITS){1'b0}}, out_pressed, out_pres,
                          out_rot, out_id, out_kind};

`ifndef SYNTHESIS
  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> (byte_count == '0 && magic_word == '0))
    else $error("working state not cleared after last byte");

  a_snap_held: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !out_free) |=> snap_valid)
    else $error("snapshot lost while result stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_NONE) |->
      (out_id == '0 && out_rot == '0 && out_pres == '0 && !out_pressed))
    else $error("rejected result carries nonzero fields");

  a_pad_id_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_PAD || out_kind == KIND_KNOB)) |-> (out_id[31:4] == '0))
    else $error("pad or knob index out of range");
`endif

endmodule

// ----- bench/controller_event_message_decoder_tb.sv -----
// Testbench for controller_event_message_decoder: directed and random messages
// under several idle/stall mixes, checked against an in-bench decoder model.
// Depends on cemd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module controller_event_message_decoder_tb;
  import cemd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_LEN       = 300;
  localparam int RANDOM_BYTES   = 80;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] control_id;
    logic [31:0] rotation;
    logic [31:0] pressure;
    logic        pressed;
  } ctl_event_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic                   s_axis_tlast = 1'b0;   // last_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [2:0] event_kind, [34:3] control_id, [66:35] rotation,
  // [98:67] pressure, [99] pressed, upper bits zero
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  // decoder model state
  logic [4:0]  msg_count = '0;
  logic [31:0] msg_magic = '0;
  logic [31:0] msg_w12 = '0;
  logic [31:0] msg_w16 = '0;
  logic [31:0] msg_w20 = '0;
  logic [31:0] msg_w24 = '0;

  ctl_event_t pending_events[$];
  ctl_event_t want;
  ctl_event_t predicted;
  int         errors = 0;
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_pending = 0;
  int         hold_served = 0;

  controller_event_message_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Feed one byte to the model; returns 1 with the decoded event on a last byte.
  function automatic bit absorb_byte(input logic [7:0] b, input logic lst,
                                     output ctl_event_t ev);
    logic [4:0]  len;
    logic [31:0] turn;
    ev = '0;
    // offsets 4..11 and 28 up are dropped
    case (msg_count[4:2])
      3'd0: msg_magic[8*msg_count[1:0] +: 8] = b;
      3'd3: msg_w12[8*msg_count[1:0] +: 8] = b;
      3'd4: msg_w16[8*msg_count[1:0] +: 8] = b;
      3'd5: msg_w20[8*msg_count[1:0] +: 8] = b;
      3'd6: msg_w24[8*msg_count[1:0] +: 8] = b;
      default: ;
    endcase
    if (msg_count != 5'd31) msg_count = msg_count + 5'd1;
    if (!lst) return 1'b0;
    len = msg_count;
    case (msg_magic)
      MAGIC_BUTTON: begin
        if (len >= 5'd21 && msg_w12 == 32'd1) begin
          ev.kind = KIND_BUTTON;
          ev.control_id = msg_w16;
          ev.pressed = (msg_w20[7:0] != 8'h00);
        end
      end
      MAGIC_KNOB: begin
        if (len >= 5'd24 && msg_w16 < 32'd8 && msg_w20 != '0) begin
          ev.kind = KIND_KNOB;
          ev.control_id = msg_w16;
          ev.rotation = msg_w20;
        end
      end
      MAGIC_MAIN_KNOB: begin
        turn = (len >= 5'd24) ? msg_w20 : msg_w16;
        if (len >= 5'd20 && turn != '0) begin
          ev.kind = KIND_MAIN_KNOB;
          ev.rotation = turn;
        end
      end
      MAGIC_PAD: begin
        if (len >= 5'd28 && msg_w16 < 32'd16) begin
          ev.kind = KIND_PAD;
          // rows are flipped, columns kept
          ev.control_id = {28'd0, 2'd3 - msg_w16[3:2], msg_w16[1:0]};
          ev.pressure = msg_w24;
          ev.pressed = (msg_w24 != '0);
        end
      end
      default: ;
    endcase
    msg_count = '0;
    msg_magic = '0;
    msg_w12 = '0;
    msg_w16 = '0;
    msg_w20 = '0;
    msg_w24 = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, exp_val);
    errors++;
  endtask

  // input side: model every accepted transfer
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      if (absorb_byte(s_axis_tdata, s_axis_tlast, predicted))
        pending_events = {pending_events, predicted};
  end

  // output side: compare each transfer with the oldest pending event
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result, kind", {29'd0, m_axis_tdata[2:0]}, '0);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata[2:0] !== want.kind)
          report_mismatch("event_kind", {29'd0, m_axis_tdata[2:0]}, {29'd0, want.kind});
        if (m_axis_tdata[34:3] !== want.control_id)
          report_mismatch("control_id", m_axis_tdata[34:3], want.control_id);
        if (m_axis_tdata[66:35] !== want.rotation)
          report_mismatch("rotation", m_axis_tdata[66:35], want.rotation);
        if (m_axis_tdata[98:67] !== want.pressure)
          report_mismatch("pressure", m_axis_tdata[98:67], want.pressure);
        if (m_axis_tdata[99] !== want.pressed)
          report_mismatch("pressed", {31'd0, m_axis_tdata[99]}, {31'd0, want.pressed});
        if (m_axis_tdata[TDATA_OUT_W-1:100] !== '0)
          report_mismatch("pad bits", {28'd0, m_axis_tdata[TDATA_OUT_W-1:100]}, '0);
      end
    end
  end

  // result side ready: random stalls, plus a long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending != hold_served) begin
        hold_served = hold_pending;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL controller_event_message_decoder");
        $finish;
      end
    end
  end

  // Offer one byte and return at the edge that takes it; tvalid stays high.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [31:0] magic, input int len,
                              input logic [31:0] w12, input logic [31:0] w16,
                              input logic [31:0] w20, input logic [31:0] w24);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (i / 4)
        0: b = magic[8*(i%4) +: 8];
        3: b = w12[8*(i%4) +: 8];
        4: b = w16[8*(i%4) +: 8];
        5: b = w20[8*(i%4) +: 8];
        6: b = w24[8*(i%4) +: 8];
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // Sender goes quiet until every decoded event has come out.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_message();
    int          len;
    logic [31:0] magic;
    logic [31:0] w12;
    logic [31:0] w16;
    logic [31:0] w20;
    logic [31:0] w24;
    w12 = ($urandom_range(0, 3) != 0) ? 32'd1 : $urandom;
    w16 = $urandom;
    w20 = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    w24 = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(19, 31);
    case ($urandom_range(0, 9))
      0, 1: magic = MAGIC_BUTTON;
      2, 3: begin
        magic = MAGIC_KNOB;
        w16 = $urandom_range(0, 9);
      end
      4, 5: begin
        magic = MAGIC_MAIN_KNOB;
        if ($urandom_range(0, 5) == 0) w16 = '0;
      end
      6, 7: begin
        magic = MAGIC_PAD;
        w16 = $urandom_range(0, 17);
      end
      8: begin
        // near miss on a valid magic word
        case ($urandom_range(0, 3))
          0: magic = MAGIC_BUTTON;
          1: magic = MAGIC_KNOB;
          2: magic = MAGIC_MAIN_KNOB;
          default: magic = MAGIC_PAD;
        endcase
        magic[$urandom_range(0, 31)] ^= 1'b1;
      end
      default: magic = $urandom;
    endcase
    send_message(magic, len, w12, w16, w20, w24);
  endtask

  task automatic run_directed();
    // button: shortest length, only low byte of the pressed word arrives
    send_message(MAGIC_BUTTON, 21, 32'd1, 32'hFFFF_FFFF, 32'hA5A5_A501, '0);
    send_message(MAGIC_BUTTON, 24, 32'd1, 32'd0, 32'h0000_0100, '0);
    send_message(MAGIC_BUTTON, 24, 32'd2, 32'd5, 32'd1, '0);
    send_message(MAGIC_BUTTON, 20, 32'd1, 32'd5, 32'd1, '0);
    // knob: index and rotation limits, length check
    send_message(MAGIC_KNOB, 24, '0, 32'd7, 32'hFFFF_FFFF, '0);
    send_message(MAGIC_KNOB, 24, '0, 32'd0, 32'h8000_0000, '0);
    send_message(MAGIC_KNOB, 24, '0, 32'd8, 32'd1, '0);
    send_message(MAGIC_KNOB, 24, '0, 32'd3, 32'd0, '0);
    send_message(MAGIC_KNOB, 23, '0, 32'd3, 32'd1, '0);
    // main knob: rotation from word 16 below 24 bytes, word 20 from there up
    send_message(MAGIC_MAIN_KNOB, 20, '0, 32'h8000_0000, '0, '0);
    send_message(MAGIC_MAIN_KNOB, 23, '0, 32'h7FFF_FFFF, '0, '0);
    send_message(MAGIC_MAIN_KNOB, 24, '0, 32'd9, 32'hFFFF_FFFE, '0);
    send_message(MAGIC_MAIN_KNOB, 24, '0, 32'd9, 32'd0, '0);
    send_message(MAGIC_MAIN_KNOB, 19, '0, 32'd9, '0, '0);
    // pad: code extremes, out of range, short
    send_message(MAGIC_PAD, 28, '0, 32'd0, '0, 32'd0);
    send_message(MAGIC_PAD, 28, '0, 32'd15, '0, 32'hFFFF_FFFF);
    send_message(MAGIC_PAD, 28, '0, 32'd16, '0, 32'd7);
    send_message(MAGIC_PAD, 27, '0, 32'd4, '0, 32'd7);
    // long message: count saturates, tail bytes ignored
    send_message(MAGIC_PAD, 40, '0, 32'd6, '0, 32'h1234_5678);
    // unknown magic, single byte, all zero
    send_message(32'hFFFF_FFFF, 28, 32'd1, 32'd1, 32'd1, 32'd1);
    send_message('0, 1, '0, '0, '0, '0);
    send_message('0, 31, '0, '0, '0, '0);
    wait_for_results();
  endtask

  task automatic run_random(input int idle_pct, input int stall_pct, input int n_bytes);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      else
        send_random_message();
    end
    wait_for_results();
  endtask

  // Result side holds off while the sender keeps streaming, so input stalls.
  task automatic run_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_pending++;
    repeat (6) send_message(MAGIC_PAD, 28, '0, $urandom_range(0, 15), '0, $urandom);
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(0, 0, RANDOM_BYTES);
    run_random(52, 0, RANDOM_BYTES);
    run_random(0, 52, RANDOM_BYTES);
    run_random(15, 15, RANDOM_BYTES);
    run_output_hold();
    repeat (10) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch("events never delivered", pending_events.size(), '0);
    if (errors == 0)
      $display("PASS controller_event_message_decoder");
    else
      $display("FAIL controller_event_message_decoder");
    $finish;
  end

endmodule
